// ===== hw/rtl/kha_pkg.sv =====
// ----------------------------------------------------------------------------
// kha_pkg
// Shared sizes, types and codes of the key-to-id hash assigner.
// ----------------------------------------------------------------------------
`default_nettype none

package kha_pkg;

    localparam int BUCKETS    = 1024;   // power of two, the hash is masked to it
    localparam int ENTRIES    = 2048;
    localparam int HASH_SHIFT = 10;

    localparam int BKT_W  = $clog2(BUCKETS);
    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    // only the low product bits up to the top of the bucket field matter
    localparam int HASH_W = HASH_SHIFT + BKT_W;

    localparam int KEY_W = 48;
    localparam int OFS_W = 16;
    localparam int ID_W  = 17;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef struct packed {
        logic              vld;
        logic [SLOT_W-1:0] slot;
    } head_t;

    typedef struct packed {
        head_t            link;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [BKT_W-1:0] addr;
        head_t            data;
    } head_wr_t;

    typedef struct packed {
        logic             en;
        logic [BKT_W-1:0] addr;
    } head_rd_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        entry_t            data;
    } entry_wr_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } entry_rd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kha_hash.sv =====
// ----------------------------------------------------------------------------
// kha_hash
// Bucket index: bits HASH_SHIFT and up of key squared, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module kha_hash
    import kha_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [HASH_W-1:0] key_lo,
    output logic      [BKT_W-1:0]  bucket
);

    logic [HASH_W-1:0] sq;
    logic [BKT_W-1:0]  bucket_reg;

    // the low HASH_W bits of the square depend only on the low HASH_W key bits
    assign sq = key_lo * key_lo;

    always_ff @(posedge aclk) begin
        if (en) begin
            bucket_reg <= sq[HASH_SHIFT +: BKT_W];
        end
    end

    assign bucket = bucket_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/kha_head_ram.sv =====
// ----------------------------------------------------------------------------
// kha_head_ram
// Bucket head memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kha_head_ram
    import kha_pkg::*;
(
    input  wire logic     aclk,
    input  wire head_wr_t wr,
    input  wire head_rd_t rd,
    output head_t         rd_data
);

    head_t mem [BUCKETS];
    head_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/kha_entry_ram.sv =====
// ----------------------------------------------------------------------------
// kha_entry_ram
// Entry memory holding key and chain link per slot, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kha_entry_ram
    import kha_pkg::*;
(
    input  wire logic      aclk,
    input  wire entry_wr_t wr,
    input  wire entry_rd_t rd,
    output entry_t         rd_data
);

    entry_t mem [ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/key_to_id_hash_assigner_top.sv =====
// ----------------------------------------------------------------------------
// key_to_id_hash_assigner_top
// Chained hash map giving dense serial numbers to 48-bit keys.
// Lookup: the key is hashed, the bucket head is read, and each chain entry
//   visited is one step, one read of the entry memory, before the response.
// Throughput: one request at a time; the next is taken in the cycle after the
//   result is loaded into the output register.
// Clear: a write sweep over the bucket head memory, then the response on
//   m_valid.
// Reset: runs the same clearing sweep; s_ready stays low.
// ----------------------------------------------------------------------------
`default_nettype none

module key_to_id_hash_assigner_top
    import kha_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,

    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_kind,
    input  wire logic [KEY_W-1:0] s_key,
    input  wire logic [OFS_W-1:0] s_offset,

    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic      [ID_W-1:0]  m_id,
    output logic                  m_is_new,
    output logic                  m_full_res,
    output logic      [CNT_W-1:0] m_id_count
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_HASH = 3'd1;
    localparam logic [2:0] ST_HEAD = 3'd2;
    localparam logic [2:0] ST_WALK = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;
    localparam logic [2:0] ST_CLR  = 3'd5;

    logic [2:0]        state_reg,    state_next;
    logic [KEY_W-1:0]  key_reg,      key_next;
    logic [OFS_W-1:0]  ofs_reg,      ofs_next;
    head_t             head_reg,     head_next;
    logic [SLOT_W-1:0] slot_reg,     slot_next;
    logic [BKT_W-1:0]  sweep_reg,    sweep_next;
    logic              clr_resp_reg, clr_resp_next;
    logic [CNT_W-1:0]  count_reg,    count_next;
    logic [ID_W-1:0]   res_id_reg,   res_id_next;
    logic              res_new_reg,  res_new_next;
    logic              res_full_reg, res_full_next;
    logic              m_valid_reg,  m_valid_next;
    logic [ID_W-1:0]   m_id_reg,     m_id_next;
    logic              m_new_reg,    m_new_next;
    logic              m_full_reg,   m_full_next;
    logic [CNT_W-1:0]  m_count_reg,  m_count_next;

    logic              hash_en;
    logic [BKT_W-1:0]  bucket;
    head_wr_t          head_wr;
    head_rd_t          head_rd;
    head_t             head_q;
    entry_wr_t         ent_wr;
    entry_rd_t         ent_rd;
    entry_t            ent_q;
    logic              miss;
    head_t             miss_link;

    assign s_ready = (state_reg == ST_IDLE);
    assign hash_en = s_valid && s_ready;

    kha_hash u_hash (
        .aclk   (aclk),
        .en     (hash_en),
        .key_lo (s_key[HASH_W-1:0]),
        .bucket (bucket)
    );

    kha_head_ram u_head_ram (
        .aclk    (aclk),
        .wr      (head_wr),
        .rd      (head_rd),
        .rd_data (head_q)
    );

    kha_entry_ram u_entry_ram (
        .aclk    (aclk),
        .wr      (ent_wr),
        .rd      (ent_rd),
        .rd_data (ent_q)
    );

    // Reads and writes of the memories fall in distinct cycles of one
    // request, so no same-entry forwarding is needed.
    always_comb begin
        state_next    = state_reg;
        key_next      = key_reg;
        ofs_next      = ofs_reg;
        head_next     = head_reg;
        slot_next     = slot_reg;
        sweep_next    = sweep_reg;
        clr_resp_next = clr_resp_reg;
        count_next    = count_reg;
        res_id_next   = res_id_reg;
        res_new_next  = res_new_reg;
        res_full_next = res_full_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_id_next     = m_id_reg;
        m_new_next    = m_new_reg;
        m_full_next   = m_full_reg;
        m_count_next  = m_count_reg;
        head_wr       = '0;
        head_rd       = '0;
        ent_wr        = '0;
        ent_rd        = '0;
        miss          = 1'b0;
        miss_link     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    key_next = s_key;
                    ofs_next = s_offset;
                    if (s_kind == KIND_CLEAR) begin
                        sweep_next    = '0;
                        clr_resp_next = 1'b1;
                        state_next    = ST_CLR;
                    end else begin
                        state_next = ST_HASH;
                    end
                end
            end
            ST_HASH: begin
                head_rd.en   = 1'b1;
                head_rd.addr = bucket;
                state_next   = ST_HEAD;
            end
            ST_HEAD: begin
                head_next = head_q;
                if (head_q.vld) begin
                    ent_rd.en   = 1'b1;
                    ent_rd.addr = head_q.slot;
                    slot_next   = head_q.slot;
                    state_next  = ST_WALK;
                end else begin
                    miss      = 1'b1;
                    miss_link = head_q;
                end
            end
            ST_WALK: begin
                if (ent_q.key == key_reg) begin
                    res_id_next   = ID_W'(slot_reg) + ID_W'(ofs_reg);
                    res_new_next  = 1'b0;
                    res_full_next = 1'b0;
                    state_next    = ST_RESP;
                end else if (ent_q.link.vld) begin
                    // advance along the chain
                    ent_rd.en   = 1'b1;
                    ent_rd.addr = ent_q.link.slot;
                    slot_next   = ent_q.link.slot;
                end else begin
                    miss      = 1'b1;
                    miss_link = head_reg;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_id_next    = res_id_reg;
                    m_new_next   = res_new_reg;
                    m_full_next  = res_full_reg;
                    m_count_next = count_reg;
                    state_next   = ST_IDLE;
                end
            end
            ST_CLR: begin
                head_wr.en   = 1'b1;
                head_wr.addr = sweep_reg;
                head_wr.data = '0;
                sweep_next   = sweep_reg + 1'b1;
                if (sweep_reg == BKT_W'(BUCKETS - 1)) begin
                    count_next    = '0;
                    res_id_next   = '0;
                    res_new_next  = 1'b0;
                    res_full_next = 1'b0;
                    clr_resp_next = 1'b0;
                    state_next    = clr_resp_reg ? ST_RESP : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (miss) begin
            state_next = ST_RESP;
            priority if (count_reg >= CNT_W'(ENTRIES)) begin
                // table full: drop the insert
                res_id_next   = '0;
                res_new_next  = 1'b0;
                res_full_next = 1'b1;
            end else begin
                ent_wr.en          = 1'b1;
                ent_wr.addr        = count_reg[SLOT_W-1:0];
                ent_wr.data.link   = miss_link;
                ent_wr.data.key    = key_reg;
                head_wr.en         = 1'b1;
                head_wr.addr       = bucket;
                head_wr.data.vld   = 1'b1;
                head_wr.data.slot  = count_reg[SLOT_W-1:0];
                count_next         = count_reg + 1'b1;
                res_id_next        = ID_W'(count_reg[SLOT_W-1:0]) + ID_W'(ofs_reg);
                res_new_next       = 1'b1;
                res_full_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLR;
            sweep_reg    <= '0;
            clr_resp_reg <= 1'b0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sweep_reg    <= sweep_next;
            clr_resp_reg <= clr_resp_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        ofs_reg      <= ofs_next;
        head_reg     <= head_next;
        slot_reg     <= slot_next;
        res_id_reg   <= res_id_next;
        res_new_reg  <= res_new_next;
        res_full_reg <= res_full_next;
        m_id_reg     <= m_id_next;
        m_new_reg    <= m_new_next;
        m_full_reg   <= m_full_next;
        m_count_reg  <= m_count_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_id       = m_id_reg;
    assign m_is_new   = m_new_reg;
    assign m_full_res = m_full_reg;
    assign m_id_count = m_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(ENTRIES))
        else $error("entry count beyond capacity");

    a_full_only_at_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_full_res) |-> (m_id_count == CNT_W'(ENTRIES)))
        else $error("full result below capacity");

    a_new_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_is_new && m_full_res))
        else $error("new and full flagged together");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted request not started");

endmodule

`default_nettype wire
